// ===== hw/rtl/long_shadow_vertex_expander_assert.svh =====
// Assertion helpers for the shadow expander.
`ifndef LONG_SHADOW_VERTEX_EXPANDER_ASSERT_SVH
`define LONG_SHADOW_VERTEX_EXPANDER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define LSVE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define LSVE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lsve_pkg.sv =====
package lsve_pkg;

    // Layer count and position format
    localparam int MAX_LAYERS = 64;
    localparam int POS_W      = 24;
    localparam int LAYER_W    = $clog2(MAX_LAYERS + 1);
    localparam int IDX_W      = $clog2(MAX_LAYERS);
    localparam int SEG_W      = 6;
    localparam int ACC_W      = POS_W + 1;

    // Color format
    localparam int CH_W    = 8;
    localparam int COLOR_W = 32;
    localparam int NUM_CH  = 4;
    localparam int CHI_W   = $clog2(NUM_CH);
    localparam int NUM_AX  = 3;

    localparam logic [CHI_W-1:0] CH_RED   = 2'd0;
    localparam logic [CHI_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHI_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CHI_W-1:0] CH_ALPHA = 2'd3;

    // Divider: dividend width and step counter
    localparam int DIV_W      = POS_W;
    localparam int DIV_STEP_W = $clog2(DIV_W + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_EN  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AMUL_EN  = 4'd7;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 32'h0000_00FF;

    // Setup jobs: three axis divisions, then four channel divisions
    localparam int JOB_W = 3;
    localparam logic [JOB_W-1:0] JOB_FIRST_AXIS  = 3'd0;
    localparam logic [JOB_W-1:0] JOB_LAST_AXIS   = 3'd2;
    localparam logic [JOB_W-1:0] JOB_FIRST_COLOR = 3'd3;
    localparam logic [JOB_W-1:0] JOB_LAST        = 3'd6;

    // Request to the divider
    typedef struct packed {
        logic start;
        logic short_mode;   // dividend holds CH_W bits at the top
    } t_div_req;

    // Pick one byte of a packed RGBA word
    function automatic logic [CH_W-1:0] color_chan(input logic [COLOR_W-1:0] c,
                                                   input logic [CHI_W-1:0] idx);
        logic [CH_W-1:0] res;
        case (idx)
            CH_RED:   res = c[4*CH_W-1:3*CH_W];
            CH_GREEN: res = c[3*CH_W-1:2*CH_W];
            CH_BLUE:  res = c[2*CH_W-1:CH_W];
            default:  res = c[CH_W-1:0];
        endcase
        return res;
    endfunction

    // Clamp a widened coordinate to the signed position range
    function automatic logic [POS_W-1:0] sat_pos(input logic [ACC_W-1:0] v);
        logic [POS_W-1:0] res;
        if (v[ACC_W-1] != v[ACC_W-2]) begin
            res = v[ACC_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/lsve_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lsve_div
    import lsve_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    input  logic [DIV_W-1:0]   i_dividend,
    input  logic [LAYER_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_W-1:0]   o_quotient,
    output logic [LAYER_W-1:0] o_remainder
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]      r_quo;
    logic [LAYER_W-1:0]    r_rem;
    logic [LAYER_W-1:0]    r_dvs;

    logic [LAYER_W:0] w_part;
    logic [LAYER_W:0] w_diff;
    logic             w_fit;

    // Trial subtraction
    assign w_part = {r_rem, r_quo[DIV_W-1]};
    assign w_diff = w_part - {1'b0, r_dvs};
    assign w_fit  = (w_part >= {1'b0, r_dvs});

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.short_mode ? DIV_STEP_W'(CH_W) : DIV_STEP_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[LAYER_W-1:0] : w_part[LAYER_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hw/rtl/long_shadow_vertex_expander.sv =====
// Long-shadow vertex expander.
// Input channel (i_in_valid / o_in_ready) takes one source vertex: Q16.8
// position and alpha byte. For L = shadow_segments + 1 layers the block emits
// L shadow vertices on the output channel (o_out_valid / i_out_ready), layer 0
// (farthest) first, with o_last_layer set on layer L-1.
// Configuration writes (i_cfg_valid / o_cfg_ready, index and data) are always
// taken; change registers only while the block is idle.
// Per item, a shared serial divider first runs the setup: three axis
// divisions by L and, with the gradient on and L > 1, four channel divisions
// by L-1. Then one layer comes per cycle while the receiver takes results,
// and the next item is accepted only after the last layer is loaded into the
// output register. o_in_ready is high only between items.
// Results sit in an output register; a stalled receiver holds it and the
// layer sequencer waits. The last result may still wait while the next item
// is accepted.
// Reset (synchronous, active low) returns to idle, drops o_out_valid and loads
// the register defaults: no extra layers, zero sizes, colors 0x000000FF.
`include "long_shadow_vertex_expander_assert.svh"

module long_shadow_vertex_expander
    import lsve_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [POS_W-1:0] i_vertex_x,
    input  logic signed [POS_W-1:0] i_vertex_y,
    input  logic signed [POS_W-1:0] i_vertex_z,
    input  logic [CH_W-1:0]       i_source_alpha,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [POS_W-1:0] o_out_x,
    output logic signed [POS_W-1:0] o_out_y,
    output logic signed [POS_W-1:0] o_out_z,
    output logic [CH_W-1:0]       o_out_red,
    output logic [CH_W-1:0]       o_out_green,
    output logic [CH_W-1:0]       o_out_blue,
    output logic [CH_W-1:0]       o_out_alpha,
    output logic [IDX_W-1:0]      o_layer_index,
    output logic                  o_last_layer
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DSTART = 2'd1;
    localparam logic [1:0] ST_DWAIT  = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    // configuration registers
    logic [SEG_W-1:0]   r_segments;
    logic [POS_W-1:0]   r_size [NUM_AX];
    logic [COLOR_W-1:0] r_near;
    logic [COLOR_W-1:0] r_far;
    logic               r_grad_en;
    logic               r_amul_en;

    // sequencer
    logic [1:0]       r_state;
    logic [JOB_W-1:0] r_job;
    logic [IDX_W-1:0] r_k;
    logic             r_grad;

    // per-item working set
    logic [POS_W-1:0]  r_src [NUM_AX];
    logic [CH_W-1:0]   r_src_a;
    logic [POS_W-1:0]  r_step [NUM_AX];
    logic [ACC_W-1:0]  r_pos [NUM_AX];
    logic [CH_W-1:0]   r_cq [NUM_CH];
    logic [IDX_W-1:0]  r_cr [NUM_CH];
    logic [CH_W:0]     r_dq [NUM_CH];
    logic [IDX_W-1:0]  r_dr [NUM_CH];

    // output register
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_pos [NUM_AX];
    logic [CH_W-1:0]  r_out_col [NUM_CH];
    logic [IDX_W-1:0] r_out_k;
    logic             r_out_last;

    // combinational
    logic [LAYER_W-1:0] w_layers_raw;
    logic [LAYER_W-1:0] w_layers;
    logic [IDX_W-1:0]   w_last_k;
    logic               w_in_acc;
    logic               w_load;
    logic               w_is_last;
    t_div_req           w_div_req;
    logic [DIV_W-1:0]   w_div_dividend;
    logic [LAYER_W-1:0] w_div_divisor;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_div_quo;
    logic [LAYER_W-1:0] w_div_rem;
    logic [1:0]         w_ax;
    logic [POS_W-1:0]   w_size_sel;
    logic               w_size_neg;
    logic [CHI_W-1:0]   w_ch;
    logic [CH_W-1:0]    w_near_ch;
    logic [CH_W-1:0]    w_far_ch;
    logic [CH_W:0]      w_delta;
    logic               w_delta_neg;
    logic [CH_W-1:0]    w_delta_abs;
    logic [POS_W-1:0]   w_interval;
    logic [ACC_W-1:0]   w_rem_s;
    logic [ACC_W-1:0]   w_pos0;
    logic [CH_W-1:0]    w_uq;
    logic [CH_W:0]      w_dq_new;
    logic [IDX_W-1:0]   w_dr_new;
    logic [IDX_W-1:0]   w_cr_next [NUM_CH];
    logic [CH_W-1:0]    w_cq_next [NUM_CH];
    logic [2*CH_W-1:0]  w_aprod;
    logic [2*CH_W:0]    w_asum;
    logic [CH_W-1:0]    w_alpha;
    logic               w_out_st;
    logic               w_cr_ok;
    logic               w_at_start;

    // layer count, clamped
    assign w_layers_raw = {1'b0, r_segments} + LAYER_W'(1);
    assign w_layers     = (w_layers_raw > LAYER_W'(MAX_LAYERS)) ? LAYER_W'(MAX_LAYERS)
                                                                : w_layers_raw;
    assign w_last_k     = IDX_W'(w_layers - LAYER_W'(1));

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_load      = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign w_is_last   = (r_k == w_last_k);

    // divider operand selection
    assign w_ax        = r_job[1:0];
    assign w_size_sel  = r_size[w_ax];
    assign w_size_neg  = w_size_sel[POS_W-1];
    assign w_ch        = CHI_W'(r_job - JOB_FIRST_COLOR);
    assign w_near_ch   = color_chan(r_near, w_ch);
    assign w_far_ch    = color_chan(r_far, w_ch);
    assign w_delta     = {1'b0, w_near_ch} - {1'b0, w_far_ch};
    assign w_delta_neg = w_delta[CH_W];
    assign w_delta_abs = w_delta_neg ? CH_W'(-w_delta) : w_delta[CH_W-1:0];

    always_comb begin
        w_div_req.start      = (r_state == ST_DSTART);
        w_div_req.short_mode = (r_job >= JOB_FIRST_COLOR);
        if (r_job >= JOB_FIRST_COLOR) begin
            w_div_dividend = {w_delta_abs, {(DIV_W-CH_W){1'b0}}};
            w_div_divisor  = {1'b0, w_last_k};
        end else begin
            w_div_dividend = w_size_neg ? POS_W'(-w_size_sel) : w_size_sel;
            w_div_divisor  = w_layers;
        end
    end

    lsve_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_div_req),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // axis result: truncated interval and start position src + interval*L
    assign w_interval = w_size_neg ? POS_W'(-w_div_quo) : w_div_quo;
    assign w_rem_s    = w_size_neg ? ACC_W'(-ACC_W'(w_div_rem)) : ACC_W'(w_div_rem);
    assign w_pos0     = {r_src[w_ax][POS_W-1], r_src[w_ax]}
                      + {w_size_sel[POS_W-1], w_size_sel} - w_rem_s;

    // channel result: floor division of delta by L-1
    assign w_uq = w_div_quo[CH_W-1:0];
    always_comb begin
        if (!w_delta_neg) begin
            w_dq_new = {1'b0, w_uq};
            w_dr_new = w_div_rem[IDX_W-1:0];
        end else if (w_div_rem == '0) begin
            w_dq_new = -{1'b0, w_uq};
            w_dr_new = '0;
        end else begin
            w_dq_new = -{1'b0, w_uq} - (CH_W+1)'(1);
            w_dr_new = w_last_k - w_div_rem[IDX_W-1:0];
        end
    end

    // per-layer color step: quotient and remainder carried by one add
    always_comb begin
        logic [IDX_W:0] sum;
        logic           wrap;
        for (int c = 0; c < NUM_CH; c++) begin
            sum  = {1'b0, r_cr[c]} + {1'b0, r_dr[c]};
            wrap = r_grad && (sum >= {1'b0, w_last_k});
            w_cr_next[c] = wrap ? IDX_W'(sum - {1'b0, w_last_k}) : sum[IDX_W-1:0];
            w_cq_next[c] = r_cq[c] + r_dq[c][CH_W-1:0] + CH_W'(wrap);
        end
    end

    // alpha scale: floor(x / 255) for x a product of two bytes
    assign w_aprod  = r_src_a * r_cq[CH_ALPHA];
    assign w_asum   = {1'b0, w_aprod} + (2*CH_W+1)'(w_aprod >> CH_W) + (2*CH_W+1)'(1);
    assign w_alpha  = r_amul_en ? w_asum[2*CH_W-1:CH_W] : r_cq[CH_ALPHA];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segments <= '0;
            r_size[0]  <= '0;
            r_size[1]  <= '0;
            r_size[2]  <= '0;
            r_near     <= COLOR_RESET;
            r_far      <= COLOR_RESET;
            r_grad_en  <= 1'b0;
            r_amul_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SEGMENTS: r_segments <= i_cfg_data[SEG_W-1:0];
                REG_SIZE_X:   r_size[0]  <= i_cfg_data[POS_W-1:0];
                REG_SIZE_Y:   r_size[1]  <= i_cfg_data[POS_W-1:0];
                REG_SIZE_Z:   r_size[2]  <= i_cfg_data[POS_W-1:0];
                REG_NEAR:     r_near     <= i_cfg_data[COLOR_W-1:0];
                REG_FAR:      r_far      <= i_cfg_data[COLOR_W-1:0];
                REG_GRAD_EN:  r_grad_en  <= i_cfg_data[0];
                REG_AMUL_EN:  r_amul_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_job       <= JOB_FIRST_AXIS;
            r_k         <= '0;
            r_grad      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_DSTART;
                        r_job   <= JOB_FIRST_AXIS;
                        r_k     <= '0;
                        r_grad  <= r_grad_en && (w_last_k != '0);
                    end
                end
                ST_DSTART: r_state <= ST_DWAIT;
                ST_DWAIT: begin
                    if (w_div_done) begin
                        if ((r_job == JOB_LAST_AXIS && !r_grad) || r_job == JOB_LAST) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_DSTART;
                            r_job   <= r_job + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_k <= r_k + 1'b1;
                        if (w_is_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // working set
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_src[0] <= i_vertex_x;
            r_src[1] <= i_vertex_y;
            r_src[2] <= i_vertex_z;
            r_src_a  <= i_source_alpha;
            for (int c = 0; c < NUM_CH; c++) begin
                r_cq[c] <= (r_grad_en && (w_last_k != '0))
                         ? color_chan(r_far, CHI_W'(c)) : color_chan(r_near, CHI_W'(c));
                r_cr[c] <= '0;
                r_dq[c] <= '0;
                r_dr[c] <= '0;
            end
        end else if (r_state == ST_DWAIT && w_div_done) begin
            if (r_job >= JOB_FIRST_COLOR) begin
                r_dq[w_ch] <= w_dq_new;
                r_dr[w_ch] <= w_dr_new;
            end else begin
                r_step[w_ax] <= w_interval;
                r_pos[w_ax]  <= w_pos0;
            end
        end else if (w_load) begin
            for (int a = 0; a < NUM_AX; a++) begin
                r_pos[a] <= r_pos[a] - {r_step[a][POS_W-1], r_step[a]};
            end
            for (int c = 0; c < NUM_CH; c++) begin
                r_cq[c] <= w_cq_next[c];
                r_cr[c] <= w_cr_next[c];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int a = 0; a < NUM_AX; a++) begin
                r_out_pos[a] <= sat_pos(r_pos[a]);
            end
            r_out_col[CH_RED]   <= r_cq[CH_RED];
            r_out_col[CH_GREEN] <= r_cq[CH_GREEN];
            r_out_col[CH_BLUE]  <= r_cq[CH_BLUE];
            r_out_col[CH_ALPHA] <= w_alpha;
            r_out_k             <= r_k;
            r_out_last          <= w_is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_pos[0];
    assign o_out_y       = r_out_pos[1];
    assign o_out_z       = r_out_pos[2];
    assign o_out_red     = r_out_col[CH_RED];
    assign o_out_green   = r_out_col[CH_GREEN];
    assign o_out_blue    = r_out_col[CH_BLUE];
    assign o_out_alpha   = r_out_col[CH_ALPHA];
    assign o_layer_index = r_out_k;
    assign o_last_layer  = r_out_last;

    // checks
    assign w_out_st   = (r_state == ST_OUT);
    assign w_cr_ok    = (r_cr[0] < w_last_k) && (r_cr[1] < w_last_k)
                     && (r_cr[2] < w_last_k) && (r_cr[3] < w_last_k);
    assign w_at_start = (r_state == ST_DSTART) && (r_job == JOB_FIRST_AXIS) && (r_k == '0);

    `LSVE_ASSERT_SAME(a_layer_bound, i_clk, i_rst_n, w_out_st, r_k <= w_last_k, "layer overrun")
    `LSVE_ASSERT_SAME(a_done_wait, i_clk, i_rst_n, w_div_done, r_state == ST_DWAIT, "stray done")
    `LSVE_ASSERT_SAME(a_color_rem, i_clk, i_rst_n, w_out_st && r_grad, w_cr_ok, "remainder overrun")
    `LSVE_ASSERT_NEXT(a_accept_setup, i_clk, i_rst_n, w_in_acc, w_at_start, "setup not started")

endmodule

// ===== tb/tb_long_shadow_vertex_expander.sv =====
module tb_long_shadow_vertex_expander;
    import lsve_pkg::*;

    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int SETTLE_CYCLES      = 200;
    localparam int VERTICES_PER_PHASE = 52;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // One source vertex as it enters the block
    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [CH_W-1:0]         alpha;
    } t_vertex;

    // One shadow copy as it leaves the block
    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [CH_W-1:0]         red;
        logic [CH_W-1:0]         green;
        logic [CH_W-1:0]         blue;
        logic [CH_W-1:0]         alpha;
        logic [IDX_W-1:0]        layer;
        logic                    last;
    } t_shadow;

    // Shadow predictor: register shadow copy plus the queue of shadows still due
    class shadow_scoreboard;
        logic [SEG_W-1:0]        segments;
        logic signed [POS_W-1:0] size_x;
        logic signed [POS_W-1:0] size_y;
        logic signed [POS_W-1:0] size_z;
        logic [COLOR_W-1:0]      near_color;
        logic [COLOR_W-1:0]      far_color;
        logic                    grad_en;
        logic                    amul_en;
        t_shadow                 shadows_due[$];
        int                      errors;
        int                      vertices;
        int                      results;

        function new();
            segments   = '0;
            size_x     = '0;
            size_y     = '0;
            size_z     = '0;
            near_color = COLOR_RESET;
            far_color  = COLOR_RESET;
            grad_en    = 1'b0;
            amul_en    = 1'b0;
            errors     = 0;
            vertices   = 0;
            results    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SEGMENTS: segments   = data[SEG_W-1:0];
                REG_SIZE_X:   size_x     = data[POS_W-1:0];
                REG_SIZE_Y:   size_y     = data[POS_W-1:0];
                REG_SIZE_Z:   size_z     = data[POS_W-1:0];
                REG_NEAR:     near_color = data;
                REG_FAR:      far_color  = data;
                REG_GRAD_EN:  grad_en    = data[0];
                REG_AMUL_EN:  amul_en    = data[0];
                default: ;  // unused index: no effect
            endcase
        endfunction

        // Source plus truncated per-layer interval times mult, clamped to range
        function logic signed [POS_W-1:0] place(logic signed [POS_W-1:0] src,
                                                logic signed [POS_W-1:0] size,
                                                int layers, int mult);
            longint s_src, s_size, step, v, hi, lo;
            s_src  = src;
            s_size = size;
            step   = s_size / layers;
            v      = s_src + step * mult;
            hi     = (longint'(1) <<< (POS_W - 1)) - 1;
            lo     = -hi - 1;
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[POS_W-1:0];
        endfunction

        // Far-to-near blend of one channel; gradient off or a single layer takes the near color
        function int unsigned tint(int shift, int unsigned k, int unsigned layers);
            int unsigned n, f;
            n = near_color[shift +: CH_W];
            f = far_color[shift +: CH_W];
            if (!grad_en || layers <= 1) return n;
            return (n * k + f * (layers - 1 - k)) / (layers - 1);
        endfunction

        function void note_vertex(t_vertex v);
            int unsigned layers, a;
            t_shadow     s;
            layers = segments + 1;
            if (layers > MAX_LAYERS) layers = MAX_LAYERS;
            for (int unsigned k = 0; k < layers; k++) begin
                a = tint(0, k, layers);
                if (amul_en) a = (v.alpha * a) / 255;
                s.x     = place(v.x, size_x, layers, layers - k);
                s.y     = place(v.y, size_y, layers, layers - k);
                s.z     = place(v.z, size_z, layers, layers - k);
                s.red   = CH_W'(tint(3 * CH_W, k, layers));
                s.green = CH_W'(tint(2 * CH_W, k, layers));
                s.blue  = CH_W'(tint(CH_W, k, layers));
                s.alpha = a[CH_W-1:0];
                s.layer = k[IDX_W-1:0];
                s.last  = (k + 1 == layers);
                shadows_due.push_back(s);
            end
            vertices++;
        endfunction

        function void compare_field(string field, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s expected %0d got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_shadow(t_shadow got);
            t_shadow want;
            results++;
            if (shadows_due.size() == 0) begin
                $error("shadow vertex at layer %0d with none due", got.layer);
                errors++;
                return;
            end
            want = shadows_due.pop_front();
            compare_field("out_x", want.x, got.x);
            compare_field("out_y", want.y, got.y);
            compare_field("out_z", want.z, got.z);
            compare_field("out_red", want.red, got.red);
            compare_field("out_green", want.green, got.green);
            compare_field("out_blue", want.blue, got.blue);
            compare_field("out_alpha", want.alpha, got.alpha);
            compare_field("layer_index", want.layer, got.layer);
            compare_field("last_layer", want.last, got.last);
        endfunction

        function int pending();
            return shadows_due.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic signed [POS_W-1:0] i_vertex_x;
    logic signed [POS_W-1:0] i_vertex_y;
    logic signed [POS_W-1:0] i_vertex_z;
    logic [CH_W-1:0]         i_source_alpha;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [POS_W-1:0] o_out_x;
    logic signed [POS_W-1:0] o_out_y;
    logic signed [POS_W-1:0] o_out_z;
    logic [CH_W-1:0]         o_out_red;
    logic [CH_W-1:0]         o_out_green;
    logic [CH_W-1:0]         o_out_blue;
    logic [CH_W-1:0]         o_out_alpha;
    logic [IDX_W-1:0]        o_layer_index;
    logic                    o_last_layer;

    shadow_scoreboard sb;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               idle_cycles;
    int               cfg_writes;

    long_shadow_vertex_expander dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_vertex_z     (i_vertex_z),
        .i_source_alpha (i_source_alpha),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_out_alpha    (o_out_alpha),
        .o_layer_index  (o_layer_index),
        .o_last_layer   (o_last_layer)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Handshake monitor: register writes, accepted vertices, shadow checks
    always @(posedge i_clk) begin : monitor
        t_vertex seen_v;
        t_shadow seen_s;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_register(i_cfg_index, i_cfg_data);
                cfg_writes++;
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                seen_v.x     = i_vertex_x;
                seen_v.y     = i_vertex_y;
                seen_v.z     = i_vertex_z;
                seen_v.alpha = i_source_alpha;
                sb.note_vertex(seen_v);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                seen_s.x     = o_out_x;
                seen_s.y     = o_out_y;
                seen_s.z     = o_out_z;
                seen_s.red   = o_out_red;
                seen_s.green = o_out_green;
                seen_s.blue  = o_out_blue;
                seen_s.alpha = o_out_alpha;
                seen_s.layer = o_layer_index;
                seen_s.last  = o_last_layer;
                sb.check_shadow(seen_s);
                moved = 1'b1;
            end
        end
        idle_cycles = (moved || !i_rst_n) ? 0 : idle_cycles + 1;
    end

    // Watchdog: too long without any handshake
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("watchdog: %0d idle cycles, %0d shadow vertices still due",
                 idle_cycles, sb.pending());
        $display("[long_shadow_vertex_expander] ERROR");
        $finish;
    end

    // All drive tasks start and end at a falling edge
    task automatic send_vertex(t_vertex v);
        i_cfg_valid = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_vertex_x     = v.x;
        i_vertex_y     = v.y;
        i_vertex_z     = v.z;
        i_source_alpha = v.alpha;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_for_shadows();
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Coordinate mix: extremes, near-extremes, small values, anything
    function automatic logic signed [POS_W-1:0] random_coord();
        logic signed [POS_W-1:0] c;
        case ($urandom_range(9))
            0:       c = POS_MAX;
            1:       c = POS_MIN;
            2:       c = POS_W'(POS_MAX - $urandom_range(4095));
            3:       c = POS_W'(POS_MIN + $urandom_range(4095));
            4, 5:    c = POS_W'($urandom_range(8191) - 4096);
            default: c = POS_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic t_vertex random_vertex();
        t_vertex v;
        v.x = random_coord();
        v.y = random_coord();
        v.z = random_coord();
        case ($urandom_range(3))
            0:       v.alpha = '0;
            1:       v.alpha = '1;
            default: v.alpha = CH_W'($urandom);
        endcase
        return v;
    endfunction

    // New register set; layer counts lean small, upper data bits are junk
    task automatic pick_random_setup();
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_IDX_W-1:0]  axis_reg [3];
        axis_reg = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
        word = $urandom;
        case ($urandom_range(9))
            0:       word[SEG_W-1:0] = '0;
            1:       word[SEG_W-1:0] = '1;
            7, 8:    word[SEG_W-1:0] = SEG_W'($urandom_range(31, 8));
            9:       word[SEG_W-1:0] = SEG_W'($urandom_range(62, 32));
            default: word[SEG_W-1:0] = SEG_W'($urandom_range(7, 1));
        endcase
        write_reg(REG_SEGMENTS, word);
        foreach (axis_reg[a]) begin
            if ($urandom_range(9) < 7) begin
                word = $urandom;
                word[POS_W-1:0] = random_coord();
                write_reg(axis_reg[a], word);
            end
        end
        if ($urandom_range(1)) write_reg(REG_NEAR, $urandom);
        if ($urandom_range(1)) write_reg(REG_FAR, $urandom);
        write_reg(REG_GRAD_EN, $urandom);
        write_reg(REG_AMUL_EN, $urandom);
        if ($urandom_range(7) == 0)
            write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_AMUL_EN + 1)),
                      $urandom);
    endtask

    initial begin : stimulus
        int sent, burst;
        int idle_plan [4];
        int stall_plan [4];
        idle_plan      = '{0, 66, 0, 21};
        stall_plan     = '{0, 0, 66, 21};
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_vertex_x     = '0;
        i_vertex_y     = '0;
        i_vertex_z     = '0;
        i_source_alpha = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers: one layer, no offset, near color
        send_vertex('{24'sd0, 24'sd0, 24'sd0, 8'd0});
        send_vertex('{POS_MAX, POS_MIN, POS_MAX, 8'd255});
        wait_for_shadows();

        // Deepest stack, full-scale sizes both signs, white to black, alpha multiply
        write_reg(REG_SEGMENTS, 32'hFFFF_FFFF);
        write_reg(REG_SIZE_X, 32'hA57F_FFFF);
        write_reg(REG_SIZE_Y, 32'h0080_0000);
        write_reg(REG_SIZE_Z, 32'hFF00_0100);
        write_reg(REG_NEAR, 32'hFFFF_FFFF);
        write_reg(REG_FAR, 32'h0000_0000);
        write_reg(REG_GRAD_EN, 32'hFFFF_FFFF);
        write_reg(REG_AMUL_EN, 32'h8000_0001);
        // unused indexes must leave everything alone
        write_reg(CFG_IDX_W'(REG_AMUL_EN + 1), 32'hFFFF_FFFF);
        write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 32'h0000_0000);
        send_vertex('{POS_MAX, POS_MIN, 24'sd0, 8'd255});
        send_vertex('{POS_MIN, POS_MAX, 24'sd128, 8'd0});
        send_vertex('{24'sd0, 24'sd0, POS_MIN, 8'd128});
        send_vertex('{POS_MAX, POS_MAX, POS_MAX, 8'd1});
        wait_for_shadows();

        // Gradient on with a single layer falls back to the near color
        write_reg(REG_SEGMENTS, 32'h0000_0000);
        write_reg(REG_NEAR, 32'h1234_5680);
        write_reg(REG_FAR, 32'hEDCB_A97F);
        send_vertex('{24'sd1, -24'sd1, 24'sd255, 8'd200});
        send_vertex(random_vertex());
        wait_for_shadows();

        // Two layers, tiny negative sizes truncate toward zero
        write_reg(REG_SEGMENTS, 32'h0000_0001);
        write_reg(REG_SIZE_X, 32'hFFFF_FFFD);
        write_reg(REG_SIZE_Y, 32'h0000_0003);
        write_reg(REG_SIZE_Z, 32'h00FF_FFFF);
        write_reg(REG_NEAR, 32'h00FF_00FF);
        write_reg(REG_FAR, 32'hFF00_FF00);
        write_reg(REG_AMUL_EN, 32'h0000_0000);
        send_vertex('{-24'sd5, 24'sd7, POS_MIN, 8'd77});
        send_vertex('{POS_MAX, POS_MIN, 24'sd0, 8'd255});
        send_vertex(random_vertex());
        wait_for_shadows();

        // Three layers, gradient off, alpha multiply on
        write_reg(REG_SEGMENTS, 32'h0000_0002);
        write_reg(REG_GRAD_EN, 32'h0000_0000);
        write_reg(REG_AMUL_EN, 32'h0000_0001);
        write_reg(REG_NEAR, 32'hFFFF_FF80);
        send_vertex('{24'sd100, -24'sd100, 24'sd0, 8'd255});
        send_vertex('{24'sd0, 24'sd0, 24'sd0, 8'd3});

        // Random traffic under the four pacing phases
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            sent = 0;
            while (sent < VERTICES_PER_PHASE) begin
                wait_for_shadows();
                pick_random_setup();
                burst = $urandom_range(12, 3);
                for (int i = 0; i < burst; i++) begin
                    // occasionally hold off until the block has emptied
                    if ($urandom_range(15) == 0) wait_for_shadows();
                    send_vertex(random_vertex());
                    sent++;
                end
            end
        end

        wait_for_shadows();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("run covered %0d source vertices, %0d shadow vertices, %0d register writes",
                 sb.vertices, sb.results, cfg_writes);
        $display("pacing: free flow, sender gaps, receiver stalls, and both together");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[long_shadow_vertex_expander] OK");
        end else begin
            $display("%0d mismatches, %0d shadow vertices never arrived",
                     sb.errors, sb.pending());
            $display("[long_shadow_vertex_expander] ERROR");
        end
        $finish;
    end

endmodule

// ===== long_shadow_vertex_expander.f =====
+incdir+hw/rtl
hw/rtl/lsve_pkg.sv
hw/rtl/lsve_div.sv
hw/rtl/long_shadow_vertex_expander.sv
tb/tb_long_shadow_vertex_expander.sv
